### sv/lds_pkg.sv
// Package for the LED digit scan driver: item and result types, position and
// key mode codes, and the segment pattern tables. No dependencies.
`timescale 1ns / 1ps

package lds_pkg;

    localparam int NUM_POSITIONS = 6;
    localparam int POS_W         = 3;
    localparam int SEG_W         = 7;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 16;

    // Scan positions
    localparam logic [POS_W-1:0] POS_MIN_TENS  = 3'd0;
    localparam logic [POS_W-1:0] POS_MIN_UNITS = 3'd1;
    localparam logic [POS_W-1:0] POS_POWER     = 3'd2;
    localparam logic [POS_W-1:0] POS_SEC_TENS  = 3'd3;
    localparam logic [POS_W-1:0] POS_SEC_UNITS = 3'd4;
    localparam logic [POS_W-1:0] POS_COLOR     = 3'd5;
    localparam logic [POS_W-1:0] POS_LAST      = 3'(NUM_POSITIONS - 1);

    // Key modes
    localparam logic [1:0] KEY_OFF   = 2'd0;
    localparam logic [1:0] KEY_COLOR = 2'd2;

    // Fixed segment patterns
    localparam logic [SEG_W-1:0] SEG_BLANK    = 7'h00;
    localparam logic [SEG_W-1:0] SEG_COLON    = 7'h14;
    localparam logic [SEG_W-1:0] SEG_FAULT_E  = 7'h79;
    localparam logic [SEG_W-1:0] SEG_FAULT_1  = 7'h06;
    localparam logic [SEG_W-1:0] SEG_FULL_RING = 7'h3F;

    typedef struct packed {
        logic       colon_value;
        logic       colon_write;
        logic [1:0] key_mode;
        logic       power_fault;
        logic [4:0] hue_level;
        logic [2:0] bar_level;
        logic [5:0] second;
        logic [5:0] minute;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0]         position;
        logic [NUM_POSITIONS-1:0] common_lines_n;
        logic [SEG_W-1:0]         segments;
    } t_result;

    // Decimal digit to segments
    function automatic logic [SEG_W-1:0] digit_pat(input logic [3:0] d);
        logic [SEG_W-1:0] p;
        unique case (d)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = 7'h3F;
        endcase
        return p;
    endfunction

    // Battery bar, levels above the table saturate to the top entry
    function automatic logic [SEG_W-1:0] bar_pat(input logic [2:0] lvl);
        logic [SEG_W-1:0] p;
        unique case (lvl)
            3'd0:    p = 7'h00;
            3'd1:    p = 7'h01;
            3'd2:    p = 7'h03;
            3'd3:    p = 7'h0B;
            3'd4:    p = 7'h2B;
            default: p = 7'h6B;
        endcase
        return p;
    endfunction

    // Colour pattern, levels above the table saturate to the top entry
    function automatic logic [SEG_W-1:0] hue_pat(input logic [4:0] lvl);
        logic [SEG_W-1:0] p;
        unique case (lvl)
            5'd0:    p = 7'h01;
            5'd1:    p = 7'h05;
            5'd2:    p = 7'h15;
            5'd3:    p = 7'h11;
            5'd4:    p = 7'h0D;
            5'd5:    p = 7'h1D;
            5'd6:    p = 7'h31;
            5'd7:    p = 7'h35;
            5'd8:    p = 7'h3D;
            5'd9:    p = 7'h03;
            5'd10:   p = 7'h07;
            5'd11:   p = 7'h17;
            5'd12:   p = 7'h13;
            5'd13:   p = 7'h0F;
            5'd14:   p = 7'h1F;
            5'd15:   p = 7'h3F;
            5'd16:   p = 7'h33;
            5'd17:   p = 7'h37;
            5'd18:   p = 7'h04;
            5'd19:   p = 7'h14;
            5'd20:   p = 7'h34;
            5'd21:   p = 7'h0C;
            5'd22:   p = 7'h1C;
            5'd23:   p = 7'h10;
            default: p = 7'h30;
        endcase
        return p;
    endfunction

    // Tens digit of a 6-bit value: (v * 13) >> 7 is exact for 0..63
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [9:0] prod;
        prod = 10'(v) * 10'd13;
        return prod[9:7];
    endfunction

    // Units digit: v - 10 * tens
    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] t10;
        logic [5:0] diff;
        t10  = 6'(tens_of(v)) * 6'd10;
        diff = v - t10;
        return diff[3:0];
    endfunction

endpackage

### sv/lds_in_reg.sv
// Input register of the LED digit scan driver: takes a slave-side transfer,
// unpacks tdata into an item and holds it until the core consumes it.
// Depends on lds_pkg.
`timescale 1ns / 1ps

module lds_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [lds_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_advance,
    output logic                           o_valid,
    output lds_pkg::t_item                 o_item
);

    logic           r_valid;
    lds_pkg::t_item r_item;
    logic           take;

    // Free slot, or the held item leaves in this cycle
    assign o_s_tready = !r_valid || i_advance;
    assign take       = i_s_tvalid && o_s_tready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, fields packed from bit 0 up in reverse item order, minute lowest
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= lds_pkg::t_item'(i_s_tdata[$bits(lds_pkg::t_item)-1:0]);
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/lds_scan_core.sv
// Scan core of the LED digit scan driver: holds scan position and colon flag,
// builds the segment pattern and common lines for the current position.
// Depends on lds_pkg.
`timescale 1ns / 1ps

module lds_scan_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  lds_pkg::t_item   i_item,
    output lds_pkg::t_result o_result
);

    logic [lds_pkg::POS_W-1:0] r_scan_pos;
    logic [lds_pkg::POS_W-1:0] n_scan_pos;
    logic                      r_colon;
    logic                      n_colon;

    logic                        colon_eff;
    logic                        key_off;
    logic [lds_pkg::SEG_W-1:0]   seg;
    logic [lds_pkg::SEG_W-1:0]   time_seg;

    // Colon write applies before the scan step
    assign colon_eff = i_item.colon_write ? i_item.colon_value : r_colon;
    assign key_off   = (i_item.key_mode == lds_pkg::KEY_OFF);

    // Time digits, or the fault code
    always_comb begin
        if (i_item.power_fault) begin
            unique case (r_scan_pos)
                lds_pkg::POS_SEC_TENS:  time_seg = lds_pkg::SEG_FAULT_E;
                lds_pkg::POS_SEC_UNITS: time_seg = lds_pkg::SEG_FAULT_1;
                default:                time_seg = lds_pkg::SEG_BLANK;
            endcase
        end else begin
            unique case (r_scan_pos)
                lds_pkg::POS_MIN_TENS:
                    time_seg = lds_pkg::digit_pat({1'b0, lds_pkg::tens_of(i_item.minute)});
                lds_pkg::POS_MIN_UNITS:
                    time_seg = lds_pkg::digit_pat(lds_pkg::units_of(i_item.minute));
                lds_pkg::POS_SEC_TENS:
                    time_seg = lds_pkg::digit_pat({1'b0, lds_pkg::tens_of(i_item.second)});
                default:
                    time_seg = lds_pkg::digit_pat(lds_pkg::units_of(i_item.second));
            endcase
        end
    end

    // Per-position selection and colon flag update
    always_comb begin
        n_colon = colon_eff;
        unique case (r_scan_pos)
            lds_pkg::POS_POWER: begin
                seg = lds_pkg::bar_pat(i_item.bar_level);
                if (colon_eff && !i_item.power_fault) begin
                    seg = seg | lds_pkg::SEG_COLON;
                end
            end
            lds_pkg::POS_COLOR: begin
                if (key_off) begin
                    seg = lds_pkg::SEG_BLANK;
                end else if (i_item.key_mode == lds_pkg::KEY_COLOR) begin
                    seg = lds_pkg::hue_pat(i_item.hue_level);
                end else begin
                    seg = lds_pkg::SEG_FULL_RING;
                end
            end
            default: begin
                if (key_off) begin
                    seg     = lds_pkg::SEG_BLANK;
                    n_colon = 1'b0;
                end else begin
                    seg = time_seg;
                end
            end
        endcase
    end

    // Cyclic position advance
    assign n_scan_pos = (r_scan_pos == lds_pkg::POS_LAST) ? '0 : r_scan_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos <= '0;
            r_colon    <= 1'b0;
        end else if (i_fire) begin
            r_scan_pos <= n_scan_pos;
            r_colon    <= n_colon;
        end
    end

    assign o_result.segments       = seg;
    assign o_result.common_lines_n = ~(lds_pkg::NUM_POSITIONS'(1) << r_scan_pos);
    assign o_result.position       = r_scan_pos;

endmodule

### sv/led_digit_scan_driver_top.sv
// Top level of the LED digit scan driver: input register, scan core and
// output register. Depends on lds_pkg, lds_in_reg and lds_scan_core.
`timescale 1ns / 1ps
//
// Usage
//   Each slave-side transfer is one scan tick carrying the time, power and
//   colour levels, fault flag, key mode and an optional colon update. Each
//   tick yields one master-side transfer with the segment pattern, the
//   active-low common lines and the position driven, positions 0..5 in turn.
//   Path: an input transfer is held in the input register, and its result
//   then in the output register.
//   Throughput: one tick per cycle unless the output stalls; the scan core
//   is a single table lookup and select between the two registers; the
//   position and colon flag update as an item enters the output register.
//   Reset (i_rst_n low, synchronous): both registers empty, scan position 0,
//   colon flag cleared.
//   Stall: while o_m_tvalid is high and i_m_tready low, the result holds;
//   the input register still takes one more tick if empty, then o_s_tready
//   drops until the result is taken.
//
module led_digit_scan_driver_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [5:0] minute, [11:6] second, [14:12] bar_level, [19:15] hue_level,
    // [20] power_fault, [22:21] key_mode, [23] colon_write, [24] colon_value,
    // [31:25] zero
    input  logic [lds_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [6:0] segments, [12:7] common_lines_n, [15:13] position
    output logic [lds_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic             core_valid;
    logic             advance;
    lds_pkg::t_item   item;
    lds_pkg::t_result result;

    logic             r_out_valid;
    lds_pkg::t_result r_out;

    // Core may hand over when the output register is empty or draining
    assign advance = core_valid && (!r_out_valid || i_m_tready);

    lds_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_advance  (advance),
        .o_valid    (core_valid),
        .o_item     (item)
    );

    lds_scan_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (item),
        .o_result (result)
    );

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = lds_pkg::OUT_TDATA_W'(r_out);

endmodule
